// ===== hdl/sorted_deadline_timer_queue_macros.svh =====
// ---------------------------------------------------------------------------
// Sorted deadline timer queue: assertion macros
// Shared property forms for the checks at the end of the top-level RTL module.
// ---------------------------------------------------------------------------
`ifndef SORTED_DEADLINE_TIMER_QUEUE_MACROS_SVH
`define SORTED_DEADLINE_TIMER_QUEUE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SDTQ_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("sdtq: implication check failed");

// The condition must never be seen outside reset.
`define SDTQ_ASSERT_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("sdtq: forbidden condition seen");

`endif

// ===== hdl/sdtq_pkg.sv =====
// ---------------------------------------------------------------------------
// Sorted deadline timer queue: package
// Defaults, request and cell operation codes, and the link between cells.
// ---------------------------------------------------------------------------
package sdtq_pkg;

    localparam int DEF_TIMER_COUNT = 16;
    localparam int DEF_TICK_BITS   = 32;

    localparam int ID_BITS   = 4;
    localparam int DUR_BITS  = 32;
    localparam int REM_BITS  = 32;
    localparam int REQ_BITS  = 2;
    localparam int IN_BYTES  = 5;
    localparam int OUT_BYTES = 5;

    localparam logic [REQ_BITS-1:0] REQ_START = 2'd0;
    localparam logic [REQ_BITS-1:0] REQ_STOP  = 2'd1;
    localparam logic [REQ_BITS-1:0] REQ_TICK  = 2'd2;
    localparam logic [REQ_BITS-1:0] REQ_QUERY = 2'd3;

    localparam logic [1:0] CELL_HOLD   = 2'd0;
    localparam logic [1:0] CELL_INS    = 2'd1;
    localparam logic [1:0] CELL_RM_ID  = 2'd2;
    localparam logic [1:0] CELL_RM_POS = 2'd3;

    localparam logic KIND_EXPIRY = 1'b0;
    localparam logic KIND_QUERY  = 1'b1;

    typedef struct packed {
        logic ge;
        logic rm;
    } link_t;

endpackage

// ===== hdl/sorted_deadline_timer_queue.sv =====
// ---------------------------------------------------------------------------
// Sorted deadline timer queue
// Tick counter and a table of one-shot or periodic timers, the running ones
// held in a row of cells ordered by deadline.
// ---------------------------------------------------------------------------
//  Channel   Direction  Carries
//  s_*       in         requests: start, stop, tick, query
//  m_*       out        expiry reports and query answers
//
// A start removes the timer from the cell row, then inserts it; a stop
// removes it; a query reads its deadline. A tick makes a single walk of
// the row, removing each expired timer, re-inserting each periodic one and
// passing over re-armed timers met later. After reset the list is empty
// and the counter is zero; no clearing pass is needed. The block waits
// while a result transaction is held on the output by a low m_tready.
// ---------------------------------------------------------------------------
`include "sorted_deadline_timer_queue_macros.svh"

module sorted_deadline_timer_queue
    import sdtq_pkg::*;
#(
    parameter int TIMER_COUNT = DEF_TIMER_COUNT,
    parameter int TICK_BITS   = DEF_TICK_BITS
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [8*IN_BYTES-1:0]  s_tdata,  // timer_id, duration, periodic
    input  logic [REQ_BITS-1:0]    s_tuser,  // req_type
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [8*OUT_BYTES-1:0] m_tdata,  // out_timer, remaining
    output logic [0:0]             m_tuser,  // kind
    output logic                   m_tlast
);

    localparam int TD = (TIMER_COUNT < 16) ? TIMER_COUNT : 16;
    localparam int TW = $clog2(TD);
    localparam int CW = $clog2(TD + 1);
    localparam int TB = TICK_BITS;
    localparam int PW = (TB < 32) ? TB : 32;
    localparam int EW = TW + TB + PW + 1;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SRM   = 3'd1;
    localparam logic [2:0] ST_INS   = 3'd2;
    localparam logic [2:0] ST_STOP  = 3'd3;
    localparam logic [2:0] ST_CHK   = 3'd4;
    localparam logic [2:0] ST_REARM = 3'd5;
    localparam logic [2:0] ST_QRY   = 3'd6;

    logic [2:0]          state_reg, state_next;
    logic [ID_BITS-1:0]  id_reg, id_next;
    logic [DUR_BITS-1:0] dur_reg, dur_next;
    logic                per_reg, per_next;
    logic [TB-1:0]       now_reg, now_next;
    logic [CW-1:0]       k_reg, k_next;
    logic                pend_valid_reg, pend_valid_next;
    logic [TW-1:0]       pend_id_reg, pend_id_next;
    logic [EW-1:0]       fire_reg, fire_next;
    logic [TD-1:0]       fired_reg, fired_next;
    logic [TB-1:0]       dl_tab_reg [TD];
    logic                tab_we;
    logic [TW-1:0]       tab_wa;
    logic [TB-1:0]       tab_wd;

    logic                m_valid_reg;
    logic [ID_BITS-1:0]  m_timer_reg, m_timer_next;
    logic                m_kind_reg, m_kind_next;
    logic [REM_BITS-1:0] m_rem_reg, m_rem_next;
    logic                m_last_reg, m_last_next;
    logic                push;
    logic                out_free;

    logic [1:0]          cell_op;
    logic [TW-1:0]       cell_key;
    logic [EW-1:0]       cell_new;
    logic [TD-1:0]       cell_valid;
    logic [EW-1:0]       cell_ent [TD];
    link_t               cell_lnk [TD];

    logic                ok;
    logic [TW-1:0]       tab_idx;
    logic [PW-1:0]       dur_per;
    logic [TB-1:0]       start_dl;
    logic [EW-1:0]       start_ent;
    logic [TW-1:0]       k_idx;
    logic                cur_valid;
    logic [EW-1:0]       cur;
    logic                cur_fired;
    logic [TB-1:0]       cur_diff;
    logic                expire;
    logic                can_go;
    logic [TB-1:0]       rearm_dl;
    logic [EW-1:0]       rearm_ent;
    logic [TB-1:0]       qdiff;

    assign ok        = {28'd0, id_reg} < 32'(TD);
    assign tab_idx   = TW'(id_reg);
    assign dur_per   = dur_reg[PW-1:0];
    assign start_dl  = (&dur_per) ? {TB{1'b1}} : now_reg + TB'(dur_per);
    assign start_ent = {per_reg, dur_per, start_dl, tab_idx};

    assign k_idx     = k_reg[TW-1:0];
    assign cur_valid = (k_reg < CW'(TD)) && cell_valid[k_idx];
    assign cur       = cell_ent[k_idx];
    assign cur_fired = fired_reg[cur[TW-1:0]];
    assign cur_diff  = now_reg - cur[TW +: TB];
    assign expire    = cur_valid && !cur_fired && !(&cur[TW+TB +: PW]) && !cur_diff[TB-1];
    assign out_free  = !m_valid_reg || m_tready;
    assign can_go    = !pend_valid_reg || out_free;

    assign rearm_dl  = now_reg + TB'(fire_reg[TW+TB +: PW]);
    assign rearm_ent = {fire_reg[EW-1], fire_reg[TW+TB +: PW], rearm_dl, fire_reg[TW-1:0]};
    assign qdiff     = dl_tab_reg[tab_idx] - now_reg;

    genvar g;
    generate
        for (g = 0; g < TD; g++) begin : g_cell
            logic          pv, nv;
            logic [EW-1:0] pe, ne;
            link_t         li;
            if (g == 0) begin : g_first
                assign pv = 1'b0;
                assign pe = '0;
                assign li = '0;
            end else begin : g_mid
                assign pv = cell_valid[g-1];
                assign pe = cell_ent[g-1];
                assign li = cell_lnk[g-1];
            end
            if (g == TD - 1) begin : g_last
                assign nv = 1'b0;
                assign ne = '0;
            end else begin : g_inner
                assign nv = cell_valid[g+1];
                assign ne = cell_ent[g+1];
            end
            sdtq_cell #(
                .TW (TW),
                .TB (TB),
                .EW (EW),
                .POS(g)
            ) u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .op       (cell_op),
                .key      (cell_key),
                .new_ent  (cell_new),
                .prv_valid(pv),
                .prv_ent  (pe),
                .nxt_valid(nv),
                .nxt_ent  (ne),
                .lnk_in   (li),
                .lnk_out  (cell_lnk[g]),
                .valid_o  (cell_valid[g]),
                .ent_o    (cell_ent[g])
            );
        end
    endgenerate

    always_comb begin
        state_next      = state_reg;
        id_next         = id_reg;
        dur_next        = dur_reg;
        per_next        = per_reg;
        now_next        = now_reg;
        k_next          = k_reg;
        pend_valid_next = pend_valid_reg;
        pend_id_next    = pend_id_reg;
        fire_next       = fire_reg;
        fired_next      = fired_reg;
        tab_we          = 1'b0;
        tab_wa          = tab_idx;
        tab_wd          = '0;
        cell_op         = CELL_HOLD;
        cell_key        = tab_idx;
        cell_new        = start_ent;
        push            = 1'b0;
        m_timer_next    = ID_BITS'(pend_id_reg);
        m_kind_next     = KIND_EXPIRY;
        m_rem_next      = '0;
        m_last_next     = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    id_next  = s_tdata[ID_BITS-1:0];
                    dur_next = s_tdata[ID_BITS +: DUR_BITS];
                    per_next = s_tdata[ID_BITS+DUR_BITS];
                    unique case (s_tuser)
                        REQ_START: state_next = ST_SRM;
                        REQ_STOP:  state_next = ST_STOP;
                        REQ_TICK: begin
                            now_next   = now_reg + 1'b1;
                            k_next     = '0;
                            fired_next = '0;
                            state_next = ST_CHK;
                        end
                        default:   state_next = ST_QRY;
                    endcase
                end
            end
            ST_SRM: begin
                if (ok) begin
                    cell_op    = CELL_RM_ID;
                    state_next = ST_INS;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_INS: begin
                cell_op    = CELL_INS;
                tab_we     = 1'b1;
                tab_wd     = start_dl;
                state_next = ST_IDLE;
            end
            ST_STOP: begin
                if (ok) begin
                    cell_op = CELL_RM_ID;
                    tab_we  = 1'b1;
                end
                state_next = ST_IDLE;
            end
            ST_CHK: begin
                if (expire) begin
                    if (can_go) begin
                        push            = pend_valid_reg;
                        cell_op         = CELL_RM_POS;
                        cell_key        = k_idx;
                        pend_valid_next = 1'b1;
                        pend_id_next    = cur[TW-1:0];
                        fire_next       = cur;
                        fired_next[cur[TW-1:0]] = 1'b1;
                        if (cur[EW-1]) begin
                            state_next = ST_REARM;
                        end
                    end
                end else if (cur_valid && cur_fired) begin
                    k_next = k_reg + 1'b1;
                end else if (pend_valid_reg) begin
                    if (out_free) begin
                        push            = 1'b1;
                        m_last_next     = 1'b1;
                        pend_valid_next = 1'b0;
                        state_next      = ST_IDLE;
                    end
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_REARM: begin
                cell_op    = CELL_INS;
                cell_new   = rearm_ent;
                tab_we     = 1'b1;
                tab_wa     = fire_reg[TW-1:0];
                tab_wd     = rearm_dl;
                k_next     = cell_lnk[k_idx].ge ? k_reg + 1'b1 : k_reg;
                state_next = ST_CHK;
            end
            ST_QRY: begin
                if (out_free) begin
                    push         = 1'b1;
                    m_timer_next = id_reg;
                    m_kind_next  = KIND_QUERY;
                    m_rem_next   = ok ? REM_BITS'(qdiff) : '0;
                    m_last_next  = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            now_reg        <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
            for (int i = 0; i < TD; i++) begin
                dl_tab_reg[i] <= '0;
            end
        end else begin
            state_reg      <= state_next;
            now_reg        <= now_next;
            pend_valid_reg <= pend_valid_next;
            if (push) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (tab_we) begin
                dl_tab_reg[tab_wa] <= tab_wd;
            end
        end
        id_reg      <= id_next;
        dur_reg     <= dur_next;
        per_reg     <= per_next;
        k_reg       <= k_next;
        pend_id_reg <= pend_id_next;
        fire_reg    <= fire_next;
        fired_reg   <= fired_next;
        if (push) begin
            m_timer_reg <= m_timer_next;
            m_kind_reg  <= m_kind_next;
            m_rem_reg   <= m_rem_next;
            m_last_reg  <= m_last_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(8*OUT_BYTES-ID_BITS-REM_BITS){1'b0}}, m_rem_reg, m_timer_reg};
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;

    `SDTQ_ASSERT_IMP(a_query_last, aclk, aresetn, m_tvalid && m_tuser[0], m_tlast)
    `SDTQ_ASSERT_IMP(a_idle_no_pend, aclk, aresetn, s_tready, !pend_valid_reg)
    `SDTQ_ASSERT_NEVER(a_rearm_bound, aclk, aresetn, state_reg == ST_REARM && k_reg >= CW'(TD))

    generate
        for (g = 0; g < TD - 1; g++) begin : g_chk
            `SDTQ_ASSERT_IMP(a_packed, aclk, aresetn, !cell_valid[g], !cell_valid[g+1])
        end
    endgenerate

endmodule

// ===== hdl/sdtq_cell.sv =====
// ---------------------------------------------------------------------------
// Sorted deadline timer queue: list cell
// One place of the deadline-ordered list. It shifts towards the tail on an
// insertion ahead of it and towards the head on a removal ahead of it.
// ---------------------------------------------------------------------------
module sdtq_cell
    import sdtq_pkg::*;
#(
    parameter int TW  = 4,
    parameter int TB  = 32,
    parameter int EW  = 69,
    parameter int POS = 0
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic [1:0]    op,
    input  logic [TW-1:0] key,
    input  logic [EW-1:0] new_ent,
    input  logic          prv_valid,
    input  logic [EW-1:0] prv_ent,
    input  logic          nxt_valid,
    input  logic [EW-1:0] nxt_ent,
    input  link_t         lnk_in,
    output link_t         lnk_out,
    output logic          valid_o,
    output logic [EW-1:0] ent_o
);

    localparam logic [TW-1:0] POS_KEY = TW'(POS);

    logic          valid_reg, valid_next;
    logic [EW-1:0] ent_reg, ent_next;
    logic          ge_here;
    logic          hit;

    assign ge_here = !valid_reg || (ent_reg[TW +: TB] >= new_ent[TW +: TB]);
    assign hit = ((op == CELL_RM_ID) && valid_reg && (ent_reg[TW-1:0] == key)) ||
                 ((op == CELL_RM_POS) && (key == POS_KEY));

    assign lnk_out.ge = ge_here;
    assign lnk_out.rm = lnk_in.rm | hit;

    always_comb begin
        valid_next = valid_reg;
        ent_next   = ent_reg;
        unique case (op)
            CELL_INS: begin
                if (lnk_in.ge) begin
                    valid_next = prv_valid;
                    ent_next   = prv_ent;
                end else if (ge_here) begin
                    valid_next = 1'b1;
                    ent_next   = new_ent;
                end
            end
            CELL_RM_ID, CELL_RM_POS: begin
                if (lnk_out.rm) begin
                    valid_next = nxt_valid;
                    ent_next   = nxt_ent;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        ent_reg <= ent_next;
    end

    assign valid_o = valid_reg;
    assign ent_o   = ent_reg;

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// Testbench for the sorted deadline timer queue
// Drives start, stop, tick and query requests with random gaps and in a
// back-to-back phase, predicts the expiry reports and query answers from a
// private model of the timer list, and checks every result transaction field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
    import sdtq_pkg::*;

    localparam int NTIMERS = 16;
    localparam int NO_LINK = NTIMERS;
    localparam logic [31:0] PARK = 32'hFFFF_FFFF;

    typedef struct {
        logic [3:0]  tmr;
        logic        kind;
        logic [31:0] rem;
        logic        last;
    } timer_result_t;

    class timer_scoreboard;
        logic [31:0]   ticks;
        logic [31:0]   due[NTIMERS];
        logic [31:0]   reload[NTIMERS];
        logic          repeats[NTIMERS];
        logic          running[NTIMERS];
        int            succ[NTIMERS];
        int            first;
        timer_result_t awaited[$];
        int            errors;

        function new();
            ticks = '0;
            first = NO_LINK;
            errors = 0;
            for (int i = 0; i < NTIMERS; i++) begin
                due[i] = '0;
                reload[i] = '0;
                repeats[i] = 1'b0;
                running[i] = 1'b0;
                succ[i] = 0;
            end
        endfunction

        function void detach(int id);
            int p;
            if (!running[id])
                return;
            if (first == id) begin
                first = succ[id];
            end else begin
                p = first;
                for (int s = 0; s < NTIMERS && p < NTIMERS; s++) begin
                    if (succ[p] == id) begin
                        succ[p] = succ[id];
                        break;
                    end
                    p = succ[p];
                end
            end
            running[id] = 1'b0;
        endfunction

        function void insert(int id, logic [31:0] dur);
            int prev;
            int p;
            int s;
            prev = NO_LINK;
            p = first;
            s = 0;
            reload[id] = dur;
            due[id] = (dur == PARK) ? PARK : ticks + dur;
            while (p < NTIMERS && s < NTIMERS && due[id] > due[p]) begin
                prev = p;
                p = succ[p];
                s++;
            end
            succ[id] = p;
            if (prev == NO_LINK)
                first = id;
            else
                succ[prev] = id;
            running[id] = 1'b1;
        endfunction

        function void note_request(logic [1:0] req, logic [3:0] id,
                                   logic [31:0] dur, logic per);
            timer_result_t r;
            logic [NTIMERS-1:0] fired;
            logic [31:0] late;
            int p;
            int s;
            int n;
            n = 0;
            fired = '0;
            case (req)
                REQ_START: begin
                    detach(id);
                    repeats[id] = per;
                    insert(id, dur);
                end
                REQ_STOP: begin
                    detach(id);
                    due[id] = '0;
                end
                REQ_TICK: begin
                    ticks = ticks + 1;
                    while (n < NTIMERS) begin
                        p = first;
                        s = 0;
                        while (p < NTIMERS && s < NTIMERS && fired[p]) begin
                            p = succ[p];
                            s++;
                        end
                        if (p >= NTIMERS || s >= NTIMERS)
                            break;
                        if (reload[p] == PARK)
                            break;
                        late = ticks - due[p];
                        if (late[31])
                            break;
                        detach(p);
                        fired[p] = 1'b1;
                        r.tmr = p[3:0];
                        r.kind = KIND_EXPIRY;
                        r.rem = '0;
                        r.last = 1'b0;
                        awaited.push_back(r);
                        n++;
                        if (repeats[p])
                            insert(p, reload[p]);
                    end
                    if (n > 0)
                        awaited[$].last = 1'b1;
                end
                default: begin
                    r.tmr = id;
                    r.kind = KIND_QUERY;
                    r.rem = due[id] - ticks;
                    r.last = 1'b1;
                    awaited.push_back(r);
                end
            endcase
        endfunction

        function void check_result(logic [3:0] tmr, logic kind, logic [31:0] rem,
                                   logic last);
            timer_result_t e;
            if (awaited.size() == 0) begin
                $display("%0t: unexpected result timer=%0d kind=%0d rem=%h last=%0d",
                         $time, tmr, kind, rem, last);
                errors++;
                return;
            end
            e = awaited.pop_front();
            if (tmr !== e.tmr) begin
                $display("%0t: timer expected %0d actual %0d", $time, e.tmr, tmr);
                errors++;
            end
            if (kind !== e.kind) begin
                $display("%0t: kind expected %0d actual %0d", $time, e.kind, kind);
                errors++;
            end
            if (rem !== e.rem) begin
                $display("%0t: remaining expected %h actual %h", $time, e.rem, rem);
                errors++;
            end
            if (last !== e.last) begin
                $display("%0t: last expected %0d actual %0d", $time, e.last, last);
                errors++;
            end
        endfunction
    endclass

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [8*IN_BYTES-1:0]  s_tdata;
    logic [REQ_BITS-1:0]    s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [8*OUT_BYTES-1:0] m_tdata;
    logic [0:0]             m_tuser;
    logic                   m_tlast;

    timer_scoreboard sb;
    int  cycles;
    bit  hold_off;
    bit  no_gaps;

    sorted_deadline_timer_queue dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial aclk = 1'b0;
    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("FAIL sorted_deadline_timer_queue");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata[3:0], m_tuser[0], m_tdata[35:4], m_tlast);
    end

    task automatic send_request(logic [1:0] req, logic [3:0] id, logic [31:0] dur,
                                logic per);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 15);
        repeat (gap) begin
            @(negedge aclk);
            s_tvalid = 1'b0;
        end
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tuser = req;
        s_tdata = {3'b000, per, dur, id};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        sb.note_request(req, id, dur, per);
    endtask

    task automatic send_random;
        int pick;
        logic [1:0] req;
        logic [31:0] dur;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            req = REQ_START;
        else if (pick < 50)
            req = REQ_STOP;
        else if (pick < 80)
            req = REQ_TICK;
        else
            req = REQ_QUERY;
        pick = $urandom_range(0, 9);
        if (pick < 7)
            dur = $urandom_range(0, 6);
        else if (pick == 7)
            dur = PARK;
        else if (pick == 8)
            dur = $urandom;
        else
            dur = 32'h8000_0000 + $urandom_range(0, 4) - 2;
        send_request(req, $urandom_range(0, 15), dur, $urandom_range(0, 1));
    endtask

    initial begin
        int gap;
        m_tready = 1'b0;
        forever begin
            if (hold_off) begin
                repeat (400) begin
                    @(negedge aclk);
                    m_tready = 1'b0;
                end
                hold_off = 1'b0;
            end
            gap = no_gaps ? 0 : $urandom_range(0, 15);
            repeat (gap) begin
                @(negedge aclk);
                m_tready = 1'b0;
            end
            @(negedge aclk);
            m_tready = 1'b1;
            @(posedge aclk);
            while (!m_tvalid)
                @(posedge aclk);
        end
    end

    initial begin
        sb = new();
        cycles = 0;
        hold_off = 1'b0;
        no_gaps = 1'b0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = REQ_TICK;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        send_request(REQ_START, 4'd0, 32'd0, 1'b0);
        send_request(REQ_TICK, 4'd0, 32'd0, 1'b0);
        send_request(REQ_START, 4'd1, 32'd2, 1'b1);
        send_request(REQ_START, 4'd2, 32'd0, 1'b1);
        send_request(REQ_TICK, 4'd0, 32'd0, 1'b0);
        send_request(REQ_TICK, 4'd0, 32'd0, 1'b0);
        send_request(REQ_START, 4'd3, PARK, 1'b1);
        send_request(REQ_START, 4'd4, 32'd1, 1'b0);
        send_request(REQ_TICK, 4'd0, 32'd0, 1'b0);
        send_request(REQ_QUERY, 4'd3, 32'd0, 1'b0);
        send_request(REQ_STOP, 4'd5, 32'd0, 1'b0);
        send_request(REQ_QUERY, 4'd5, 32'd0, 1'b0);
        send_request(REQ_START, 4'd1, 32'd3, 1'b0);
        send_request(REQ_QUERY, 4'd1, 32'd0, 1'b0);
        send_request(REQ_STOP, 4'd1, 32'd0, 1'b0);
        send_request(REQ_QUERY, 4'd1, 32'd0, 1'b0);
        send_request(REQ_START, 4'd15, 32'hFFFF_FFFE, 1'b1);
        send_request(REQ_QUERY, 4'd15, 32'd0, 1'b0);
        send_request(REQ_START, 4'd6, 32'h8000_0000, 1'b0);
        send_request(REQ_TICK, 4'd0, 32'd0, 1'b0);
        send_request(REQ_STOP, 4'd2, 32'd0, 1'b0);
        send_request(REQ_TICK, 4'd0, 32'd0, 1'b0);
        send_request(REQ_TICK, 4'd0, 32'd0, 1'b0);
        send_request(REQ_QUERY, 4'd0, 32'd0, 1'b0);

        for (int i = 0; i < 16; i++)
            send_request(REQ_START, i[3:0], $urandom_range(0, 2), 1'b1);
        hold_off = 1'b1;
        for (int i = 0; i < 10; i++)
            send_request(REQ_TICK, 4'd0, 32'd0, 1'b0);

        for (int i = 0; i < 70; i++) begin
            no_gaps = (i >= 40 && i < 60);
            send_random();
        end
        no_gaps = 1'b0;
        @(negedge aclk);
        s_tvalid = 1'b0;

        while (sb.awaited.size() != 0)
            @(posedge aclk);
        repeat (64) @(posedge aclk);
        if (sb.errors == 0)
            $display("PASS sorted_deadline_timer_queue");
        else
            $display("FAIL sorted_deadline_timer_queue");
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+hdl
hdl/sdtq_pkg.sv
hdl/sdtq_cell.sv
hdl/sorted_deadline_timer_queue.sv
tb/tb_top.sv
